// ===== rtl/core/tdfm_pkg.sv =====
// shared types and constants for the tilt and duty fault monitor
`default_nettype none

package tdfm_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned MAG_W   = 17;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned DATA_W  = 16;

	localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RST = 15'd23040;
	localparam logic [LIMIT_W-1:0] ROLL_LIMIT_RST  = 15'd23040;
	localparam logic [LIMIT_W-1:0] DUTY_LIMIT_RST  = 15'd32767;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PITCH = 2'd1,
		KIND_ROLL  = 2'd2,
		KIND_DUTY  = 2'd3
	} fault_kind_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_PITCH_LIMIT = 3'd0,
		REG_ROLL_LIMIT  = 3'd1,
		REG_DUTY_LIMIT  = 3'd2,
		REG_PITCH_DELAY = 3'd3,
		REG_ROLL_DELAY  = 3'd4,
		REG_DUTY_DELAY  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_W-1:0]         time_ms;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] roll;
		logic [LIMIT_W-1:0]        duty_mag;
		logic                      skip_delay;
	} in_word_t;

	typedef struct packed {
		logic        faulted;
		fault_kind_t fault_kind;
	} out_word_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] pitch_limit;
		logic [LIMIT_W-1:0] roll_limit;
		logic [LIMIT_W-1:0] duty_limit;
		logic [DELAY_W-1:0] pitch_delay_ms;
		logic [DELAY_W-1:0] roll_delay_ms;
		logic [DELAY_W-1:0] duty_delay_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic over;
		logic fault;
	} chan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/tilt_duty_fault_monitor_core.sv =====
// top level of the tilt and duty fault monitor
//
// usage
//   input channel: in_valid / in_stall / in_data carry one sample word with
//   a millisecond timestamp, pitch, roll, duty magnitude and a skip-delay flag
//   output channel: out_valid / out_stall / out_data carry one result word per
//   sample: faulted and fault_kind (none, pitch, roll, duty)
//   config port: cfg_we writes cfg_data into register cfg_index at the clock
//   edge; indexes beyond duty_delay_ms are ignored; write only while idle
//   latency: a word accepted at one edge has its result on out_valid after
//   the next edge, so the receiver can take it at the second edge; one word
//   per cycle is sustained, the stage register plus the result register set
//   the figure
//   stall: while out_stall holds a waiting result, the stage register keeps
//   its word and in_stall rises only once that stage is also full
//   reset: arst_n clears both valids, loads the default thresholds and zero
//   delays, and sets all three last-good times to zero
`default_nettype none

module tilt_duty_fault_monitor_core
	import tdfm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire in_word_t           in_data,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output out_word_t               out_data,
	input  wire logic               cfg_we,
	input  wire logic [INDEX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]  cfg_data
);

	cfg_regs_t regs;

	// stage one: sample register
	logic     valid_s1;
	in_word_t item_s1;

	// result register
	logic      res_valid_q;
	out_word_t res_q;

	// last-good timestamps, one per channel
	logic [TIME_W-1:0] pitch_ok_q;
	logic [TIME_W-1:0] roll_ok_q;
	logic [TIME_W-1:0] duty_ok_q;

	logic             advance;
	logic             take;
	logic [MAG_W-1:0] pitch_mag;
	logic [MAG_W-1:0] roll_mag;
	logic [MAG_W-1:0] duty_mag;
	chan_res_t        p_res;
	chan_res_t        r_res;
	chan_res_t        d_res;
	fault_kind_t      kind;

	tdfm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// result slot frees up when empty or being taken this cycle
	assign advance  = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take     = valid_s1 && advance;

	// 17-bit magnitudes so that the most negative angle stays positive
	always_comb begin
		pitch_mag = item_s1.pitch[ANGLE_W-1]
			? MAG_W'(17'h10000 - MAG_W'($unsigned(item_s1.pitch)))
			: MAG_W'($unsigned(item_s1.pitch));
		roll_mag  = item_s1.roll[ANGLE_W-1]
			? MAG_W'(17'h10000 - MAG_W'($unsigned(item_s1.roll)))
			: MAG_W'($unsigned(item_s1.roll));
		duty_mag  = MAG_W'(item_s1.duty_mag);
	end

	tdfm_channel u_pitch (
		.mag     (pitch_mag),
		.limit   (regs.pitch_limit),
		.delay   (regs.pitch_delay_ms),
		.ok_time (pitch_ok_q),
		.now     (item_s1.time_ms),
		.skip    (item_s1.skip_delay),
		.res     (p_res)
	);

	tdfm_channel u_roll (
		.mag     (roll_mag),
		.limit   (regs.roll_limit),
		.delay   (regs.roll_delay_ms),
		.ok_time (roll_ok_q),
		.now     (item_s1.time_ms),
		.skip    (item_s1.skip_delay),
		.res     (r_res)
	);

	tdfm_channel u_duty (
		.mag     (duty_mag),
		.limit   (regs.duty_limit),
		.delay   (regs.duty_delay_ms),
		.ok_time (duty_ok_q),
		.now     (item_s1.time_ms),
		.skip    (item_s1.skip_delay),
		.res     (d_res)
	);

	// priority: pitch, then roll, then duty
	always_comb begin
		if (p_res.fault) begin
			kind = KIND_PITCH;
		end else if (r_res.fault) begin
			kind = KIND_ROLL;
		end else if (d_res.fault) begin
			kind = KIND_DUTY;
		end else begin
			kind = KIND_NONE;
		end
	end

	// sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.faulted    <= kind != KIND_NONE;
			res_q.fault_kind <= kind;
		end
	end

	// timers: a channel behind a fault is not looked at, so keeps its time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_ok_q <= '0;
			roll_ok_q  <= '0;
			duty_ok_q  <= '0;
		end else if (take) begin
			if (!p_res.over) begin
				pitch_ok_q <= item_s1.time_ms;
			end
			if (!p_res.fault && !r_res.over) begin
				roll_ok_q <= item_s1.time_ms;
			end
			if (!p_res.fault && !r_res.fault && !d_res.over) begin
				duty_ok_q <= item_s1.time_ms;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

`ifndef NO_ASSERTIONS
	// an empty stage never holds the source back
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty sample stage");

	// faulted flag agrees with the kind on every shown result
	a_flag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.faulted == (res_q.fault_kind != KIND_NONE)))
		else $error("faulted flag and fault kind disagree");

	// an in-range pitch refreshes its last-good time
	a_pitch_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !p_res.over) |=> (pitch_ok_q == $past(item_s1.time_ms)))
		else $error("pitch last-good time not refreshed");

	// a pitch fault leaves the later timers alone
	a_skip_later: assert property (@(posedge clk) disable iff (!arst_n)
		(take && p_res.fault) |=> ($stable(roll_ok_q) && $stable(duty_ok_q)))
		else $error("timer updated behind a pitch fault");

	// a result word moves out only when a stage word was taken
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(res_valid_q) && res_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a sample");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tdfm_cfg.sv =====
// configuration register file: thresholds and delays
`default_nettype none

module tdfm_cfg
	import tdfm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [INDEX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0]   cfg_data,
	output cfg_regs_t                regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pitch_limit    <= PITCH_LIMIT_RST;
			regs_q.roll_limit     <= ROLL_LIMIT_RST;
			regs_q.duty_limit     <= DUTY_LIMIT_RST;
			regs_q.pitch_delay_ms <= '0;
			regs_q.roll_delay_ms  <= '0;
			regs_q.duty_delay_ms  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PITCH_LIMIT: regs_q.pitch_limit    <= cfg_data[LIMIT_W-1:0];
				REG_ROLL_LIMIT:  regs_q.roll_limit     <= cfg_data[LIMIT_W-1:0];
				REG_DUTY_LIMIT:  regs_q.duty_limit     <= cfg_data[LIMIT_W-1:0];
				REG_PITCH_DELAY: regs_q.pitch_delay_ms <= cfg_data[DELAY_W-1:0];
				REG_ROLL_DELAY:  regs_q.roll_delay_ms  <= cfg_data[DELAY_W-1:0];
				REG_DUTY_DELAY:  regs_q.duty_delay_ms  <= cfg_data[DELAY_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdfm_channel.sv =====
// one channel check: threshold compare and elapsed-time test
`default_nettype none

module tdfm_channel
	import tdfm_pkg::*;
(
	input  wire logic [MAG_W-1:0]   mag,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire logic [DELAY_W-1:0] delay,
	input  wire logic [TIME_W-1:0]  ok_time,
	input  wire logic [TIME_W-1:0]  now,
	input  wire logic               skip,
	output chan_res_t               res
);

	logic [TIME_W-1:0] elapsed;
	logic              over;

	always_comb begin
		over      = mag > MAG_W'(limit);
		// wrapping difference
		elapsed   = now - ok_time;
		res.over  = over;
		res.fault = over && ((elapsed > TIME_W'(delay)) || skip);
	end

endmodule

`default_nettype wire
